@@ hdl/rtcunix_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcunix_pkg
// Types, constants and helper functions shared by the RTC-to-Unix-seconds
// converter and its channel interfaces.
// ----------------------------------------------------------------------------
package rtcunix_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned YearW   = 16;
  localparam int unsigned UnixW   = 41;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 14;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTURY_PRESENT = 1'b0,
    CFG_BASE_YEAR       = 1'b1
  } cfg_idx_e;

  localparam int unsigned BaseYearReset = 2024;

  // Status register B bits and the PM flag of the hour byte
  localparam int unsigned StatusBinaryBit = 2;
  localparam int unsigned Status24hBit    = 1;
  localparam int unsigned HourPmBit       = 7;

  // floor(x / 100) as (x * Mul) >> Shift, exact for 14-bit and 16-bit x
  localparam int unsigned Div100Mul14   = 5243;
  localparam int unsigned Div100Shift14 = 19;
  localparam int unsigned Div100Mul16   = 83887;
  localparam int unsigned Div100Shift16 = 23;

  // floor(x / 12) as (x * Mul) >> Shift for 7-bit x
  localparam int unsigned Mod12Mul   = 171;
  localparam int unsigned Mod12Shift = 11;

  localparam int unsigned EpochYear        = 1970;
  localparam int unsigned LeapsBeforeEpoch = 477;  // leap years in 1..1969
  localparam int unsigned DaysPerYear      = 365;
  localparam int unsigned SecPerDay        = 86400;
  localparam int unsigned SecPerHour       = 3600;
  localparam int unsigned SecPerMin        = 60;

  // Decoded fields that ride along the pipeline to the output
  typedef struct packed {
    logic [ByteW-1:0] sec;
    logic [ByteW-1:0] min;
    logic [ByteW-1:0] hr24;
    logic [ByteW-1:0] day;
    logic [ByteW-1:0] mon;
    logic [YearW-1:0] year;
    logic             err;
  } fields_t;

  // Unchecked BCD decode: low nibble plus ten times the high nibble
  function automatic logic [ByteW-1:0] bcd_to_bin(input logic [ByteW-1:0] b);
    bcd_to_bin = 8'(b[3:0]) + 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0});
  endfunction

  // Days before the first of month m in a common year
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    case (m)
      4'd1:    month_offset = 9'd0;
      4'd2:    month_offset = 9'd31;
      4'd3:    month_offset = 9'd59;
      4'd4:    month_offset = 9'd90;
      4'd5:    month_offset = 9'd120;
      4'd6:    month_offset = 9'd151;
      4'd7:    month_offset = 9'd181;
      4'd8:    month_offset = 9'd212;
      4'd9:    month_offset = 9'd243;
      4'd10:   month_offset = 9'd273;
      4'd11:   month_offset = 9'd304;
      4'd12:   month_offset = 9'd334;
      default: month_offset = 9'd0;
    endcase
  endfunction

endpackage

@@ hdl/rtcunix_in_if.sv @@
// ----------------------------------------------------------------------------
// rtcunix_in_if
// Request channel: one raw RTC register snapshot with valid/ready.
// ----------------------------------------------------------------------------
interface rtcunix_in_if;
  logic                           valid;
  logic                           ready;
  logic [rtcunix_pkg::ByteW-1:0]  raw_seconds;
  logic [rtcunix_pkg::ByteW-1:0]  raw_minutes;
  logic [rtcunix_pkg::ByteW-1:0]  raw_hours;
  logic [rtcunix_pkg::ByteW-1:0]  raw_day;
  logic [rtcunix_pkg::ByteW-1:0]  raw_month;
  logic [rtcunix_pkg::ByteW-1:0]  raw_year;
  logic [rtcunix_pkg::ByteW-1:0]  raw_century;
  logic [rtcunix_pkg::ByteW-1:0]  status_b;

  modport source (
    output valid, raw_seconds, raw_minutes, raw_hours, raw_day, raw_month,
           raw_year, raw_century, status_b,
    input  ready
  );

  modport sink (
    input  valid, raw_seconds, raw_minutes, raw_hours, raw_day, raw_month,
           raw_year, raw_century, status_b,
    output ready
  );
endinterface

@@ hdl/rtcunix_out_if.sv @@
// ----------------------------------------------------------------------------
// rtcunix_out_if
// Result channel: decoded date/time fields and Unix seconds with valid/ready.
// ----------------------------------------------------------------------------
interface rtcunix_out_if;
  logic                           valid;
  logic                           ready;
  logic [rtcunix_pkg::ByteW-1:0]  seconds_bin;
  logic [rtcunix_pkg::ByteW-1:0]  minutes_bin;
  logic [rtcunix_pkg::ByteW-1:0]  hours_24;
  logic [rtcunix_pkg::ByteW-1:0]  day_bin;
  logic [rtcunix_pkg::ByteW-1:0]  month_bin;
  logic [rtcunix_pkg::YearW-1:0]  full_year;
  logic [rtcunix_pkg::UnixW-1:0]  unix_seconds;
  logic                           range_error;

  modport source (
    output valid, seconds_bin, minutes_bin, hours_24, day_bin, month_bin,
           full_year, unix_seconds, range_error,
    input  ready
  );

  modport sink (
    input  valid, seconds_bin, minutes_bin, hours_24, day_bin, month_bin,
           full_year, unix_seconds, range_error,
    output ready
  );
endinterface

@@ hdl/rtc_time_to_unix_seconds_core.sv @@
// ----------------------------------------------------------------------------
// rtc_time_to_unix_seconds_core
// Converts a raw CMOS RTC register snapshot into decoded fields and seconds
// since 1970-01-01 00:00:00 in a seven-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  (sink)   : one request per snapshot of the RTC bytes and status B.
//   rsp_o  (source) : one result per request, in request order.
//   cfg_*           : write port; index 0 is century_present (bit 0),
//                     index 1 is base_year. Write only while the pipe is empty.
// Stages: from request accept to result valid an item passes the seven
//   register stages (decode, hour/year, year/100, year days and leap count,
//   day sum, day*86400 and time of day, final add).
// Throughput: one request per cycle while rsp_o.ready stays high.
// Stalls: each stage holds its item while the stage after it is full and
//   stuck, so a stalled receiver fills the pipe from the output backwards;
//   req_i.ready stays high while stage one can still move or is empty.
// Reset: all stages empty, century_present = 0, base_year = 2024.
// Range error (month outside 1..12, or day 0): fields are still reported and
//   unix_seconds is zero.
// ----------------------------------------------------------------------------
module rtc_time_to_unix_seconds_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtcunix_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rtcunix_pkg::CfgDataW-1:0]    cfg_data_i,
  rtcunix_in_if.sink                          req_i,
  rtcunix_out_if.source                       rsp_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        cent_q;
  logic [13:0] base_year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_q      <= 1'b0;
      base_year_q <= 14'(rtcunix_pkg::BaseYearReset);
    end else if (cfg_we_i) begin
      case (rtcunix_pkg::cfg_idx_e'(cfg_idx_i))
        rtcunix_pkg::CFG_CENTURY_PRESENT: cent_q      <= cfg_data_i[0];
        rtcunix_pkg::CFG_BASE_YEAR:       base_year_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its item moves on
  // --------------------------------------------------------------------------
  logic [7:1] v_q;
  logic [7:1] rdy;
  logic [7:1] ld;

  always_comb begin
    rdy[7] = !v_q[7] || rsp_o.ready;
    rdy[6] = !v_q[6] || rdy[7];
    rdy[5] = !v_q[5] || rdy[6];
    rdy[4] = !v_q[4] || rdy[5];
    rdy[3] = !v_q[3] || rdy[4];
    rdy[2] = !v_q[2] || rdy[3];
    rdy[1] = !v_q[1] || rdy[2];
  end

  assign ld          = rdy & {v_q[6:1], req_i.valid};
  assign req_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (rdy & {v_q[6:1], req_i.valid}) | (~rdy & v_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: byte decode, base_year / 100
  // --------------------------------------------------------------------------
  logic        binary;
  logic        h24;
  logic [7:0]  sec_d, min_d, hr_d, day_d, mon_d, yy_d, cen_d;
  logic [26:0] base_prod;

  logic [7:0]  s1_sec_q, s1_min_q, s1_hr_q, s1_day_q, s1_mon_q, s1_yy_q, s1_cen_q;
  logic [7:0]  s1_bq_q;
  logic        s1_pm_q, s1_h24_q;

  always_comb begin
    binary = req_i.status_b[rtcunix_pkg::StatusBinaryBit];
    h24    = req_i.status_b[rtcunix_pkg::Status24hBit];
    if (binary) begin
      sec_d = req_i.raw_seconds;
      min_d = req_i.raw_minutes;
      day_d = req_i.raw_day;
      mon_d = req_i.raw_month;
      yy_d  = req_i.raw_year;
      cen_d = req_i.raw_century;
      hr_d  = h24 ? req_i.raw_hours : {1'b0, req_i.raw_hours[6:0]};
    end else begin
      sec_d = rtcunix_pkg::bcd_to_bin(req_i.raw_seconds);
      min_d = rtcunix_pkg::bcd_to_bin(req_i.raw_minutes);
      day_d = rtcunix_pkg::bcd_to_bin(req_i.raw_day);
      mon_d = rtcunix_pkg::bcd_to_bin(req_i.raw_month);
      yy_d  = rtcunix_pkg::bcd_to_bin(req_i.raw_year);
      cen_d = rtcunix_pkg::bcd_to_bin(req_i.raw_century);
      // tens digit is bits 6..4 only; bit 7 stays the PM flag
      hr_d  = 8'(req_i.raw_hours[3:0]) + 8'({req_i.raw_hours[6:4], 3'b000})
            + 8'({req_i.raw_hours[6:4], 1'b0});
    end
    base_prod = 27'(base_year_q) * 27'(rtcunix_pkg::Div100Mul14);
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_sec_q <= sec_d;
      s1_min_q <= min_d;
      s1_hr_q  <= hr_d;
      s1_day_q <= day_d;
      s1_mon_q <= mon_d;
      s1_yy_q  <= yy_d;
      s1_cen_q <= cen_d;
      s1_bq_q  <= base_prod[26:rtcunix_pkg::Div100Shift14];
      s1_pm_q  <= req_i.raw_hours[rtcunix_pkg::HourPmBit];
      s1_h24_q <= h24;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 24-hour form, full year, range check, month offset
  // --------------------------------------------------------------------------
  logic [6:0]  hr7;
  logic [14:0] m12_prod;
  logic [3:0]  q12;
  logic [6:0]  r12;
  logic [15:0] win_year;
  rtcunix_pkg::fields_t f2_d;
  logic [8:0]  moff_d;

  rtcunix_pkg::fields_t s2_f_q;
  logic [8:0]  s2_moff_q;

  always_comb begin
    // 12-hour values stay below 128 in both modes
    hr7      = s1_hr_q[6:0];
    m12_prod = 15'(hr7) * 15'(rtcunix_pkg::Mod12Mul);
    q12      = m12_prod[14:rtcunix_pkg::Mod12Shift];
    r12      = hr7 - 7'({q12, 3'b000}) - 7'({q12, 2'b00});
    if (r12 >= 7'd12) begin
      r12 = r12 - 7'd12;
    end

    win_year = 16'(s1_bq_q) * 16'd100 + 16'(s1_yy_q);
    if (win_year < 16'(base_year_q)) begin
      win_year = win_year + 16'd100;
    end

    f2_d.sec  = s1_sec_q;
    f2_d.min  = s1_min_q;
    f2_d.day  = s1_day_q;
    f2_d.mon  = s1_mon_q;
    f2_d.hr24 = s1_h24_q ? s1_hr_q : (8'(r12) + (s1_pm_q ? 8'd12 : 8'd0));
    f2_d.year = cent_q ? (16'(s1_cen_q) * 16'd100 + 16'(s1_yy_q)) : win_year;
    f2_d.err  = (s1_mon_q == 8'd0) || (s1_mon_q > 8'd12) || (s1_day_q == 8'd0);
    moff_d    = rtcunix_pkg::month_offset(s1_mon_q[3:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s2_f_q    <= f2_d;
      s2_moff_q <= moff_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: (year - 1) / 100
  // --------------------------------------------------------------------------
  logic [15:0] a3;
  logic [32:0] a3_prod;

  rtcunix_pkg::fields_t s3_f_q;
  logic [8:0]  s3_moff_q;
  logic [9:0]  s3_qa_q;

  always_comb begin
    a3      = s2_f_q.year - 16'd1;
    a3_prod = 33'(a3) * 33'(rtcunix_pkg::Div100Mul16);
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s3_f_q    <= s2_f_q;
      s3_moff_q <= s2_moff_q;
      s3_qa_q   <= a3_prod[32:rtcunix_pkg::Div100Shift16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: whole-year days, leap years since the epoch, leap-day flag
  // --------------------------------------------------------------------------
  logic [15:0] a4;
  logic [15:0] ra16;
  logic [6:0]  ra;
  logic        leap;
  logic        past;
  logic [24:0] ydays_full;
  logic [15:0] leaps_full;

  rtcunix_pkg::fields_t s4_f_q;
  logic [8:0]  s4_moff_q;
  logic [23:0] s4_ydays_q;
  logic [12:0] s4_leaps_q;
  logic        s4_ladd_q;

  always_comb begin
    a4   = s3_f_q.year - 16'd1;
    ra16 = a4 - 16'(s3_qa_q) * 16'd100;
    ra   = ra16[6:0];
    // year % 4 == 0 <=> (year-1) % 4 == 3; year % 100 == 0 <=> (year-1) % 100 == 99
    leap = (s3_f_q.year == 16'd0)
        || ((a4[1:0] == 2'b11) && ((ra != 7'd99) || (s3_qa_q[1:0] == 2'b11)));
    past = s3_f_q.year > 16'(rtcunix_pkg::EpochYear);
    ydays_full = 25'(s3_f_q.year - 16'(rtcunix_pkg::EpochYear))
               * 25'(rtcunix_pkg::DaysPerYear);
    leaps_full = 16'(a4[15:2]) - 16'(s3_qa_q) + 16'(s3_qa_q[9:2])
               - 16'(rtcunix_pkg::LeapsBeforeEpoch);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s4_f_q     <= s3_f_q;
      s4_moff_q  <= s3_moff_q;
      s4_ydays_q <= past ? ydays_full[23:0] : 24'd0;
      s4_leaps_q <= past ? leaps_full[12:0] : 13'd0;
      s4_ladd_q  <= leap && (s3_f_q.mon > 8'd2);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: total day count
  // --------------------------------------------------------------------------
  rtcunix_pkg::fields_t s5_f_q;
  logic [23:0] s5_days_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s5_f_q    <= s4_f_q;
      s5_days_q <= s4_ydays_q + 24'(s4_leaps_q) + 24'(s4_moff_q) + 24'(s4_ladd_q)
                 + 24'(s4_f_q.day) - 24'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: day seconds and time of day
  // --------------------------------------------------------------------------
  logic [19:0] tod_d;

  rtcunix_pkg::fields_t s6_f_q;
  logic [40:0] s6_dsec_q;
  logic [19:0] s6_tod_q;

  always_comb begin
    tod_d = 20'(s5_f_q.hr24) * 20'(rtcunix_pkg::SecPerHour)
          + 20'(s5_f_q.min) * 20'(rtcunix_pkg::SecPerMin)
          + 20'(s5_f_q.sec);
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s6_f_q    <= s5_f_q;
      s6_dsec_q <= 41'(s5_days_q) * 41'(rtcunix_pkg::SecPerDay);
      s6_tod_q  <= tod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: output register
  // --------------------------------------------------------------------------
  rtcunix_pkg::fields_t s7_f_q;
  logic [40:0] s7_ts_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s7_f_q  <= s6_f_q;
      // drop the time on a range error
      s7_ts_q <= s6_f_q.err ? 41'd0 : (s6_dsec_q + 41'(s6_tod_q));
    end
  end

  assign rsp_o.valid        = v_q[7];
  assign rsp_o.seconds_bin  = s7_f_q.sec;
  assign rsp_o.minutes_bin  = s7_f_q.min;
  assign rsp_o.hours_24     = s7_f_q.hr24;
  assign rsp_o.day_bin      = s7_f_q.day;
  assign rsp_o.month_bin    = s7_f_q.mon;
  assign rsp_o.full_year    = s7_f_q.year;
  assign rsp_o.unix_seconds = s7_ts_q;
  assign rsp_o.range_error  = s7_f_q.err;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_req_enters_stage1 : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v_q[1]
  ) else $error("accepted request did not enter stage 1");

  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !v_q[1] |-> req_i.ready
  ) else $error("request channel stalled with an empty first stage");

  a_err_zero_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.range_error) |-> (rsp_o.unix_seconds == '0)
  ) else $error("range error result carries nonzero seconds");

  a_no_err_fields_ok : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.range_error) |->
      ((rsp_o.month_bin >= 8'd1) && (rsp_o.month_bin <= 8'd12) && (rsp_o.day_bin != 8'd0))
  ) else $error("result without range error has invalid month or day");

endmodule
